### hdl/afc_pkg.sv
// afc_pkg: shared types, constants and the crc byte update for the ack frame checker
// no dependencies; imported by afc_core and ack_frame_checker_unit
package afc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h8408;
  localparam logic [15:0] CrcLowMask = 16'h00FF;
  localparam logic [6:0]  LenMin = 7'd5;
  localparam logic [6:0]  LenMax = 7'd64;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_CRC      = 3'd1,
    ST_ERROR_MSG    = 3'd2,
    ST_UNIDENTIFIED = 3'd3,
    ST_BAD_LENGTH   = 3'd4,
    ST_BAD_HEADER   = 3'd5
  } status_t;

  typedef enum logic [7:0] {
    REG_HEADER     = 8'd0,
    REG_RAW_TYPE   = 8'd1,
    REG_ERROR_TYPE = 8'd2,
    REG_FRAME_LEN  = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] header_value;
    logic [7:0] raw_type_value;
    logic [7:0] error_type_value;
    logic [6:0] frame_length;
  } cfg_t;

  // reflected crc-16/x.25 update, one byte, lsb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/afc_core.sv
// afc_core: per-frame state of the ack frame checker (position, crc, field checks)
// depends on afc_pkg; driven one byte per step by ack_frame_checker_unit
module afc_core (
  input  logic             clk,
  input  logic             rst,
  input  afc_pkg::cfg_t    cfg,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             first,
  output logic             result_valid,
  output afc_pkg::status_t result_status
);
  import afc_pkg::*;

  logic [6:0]  byte_count;
  logic [15:0] crc_acc;
  logic        header_good;
  logic        length_good;
  logic [7:0]  type_seen;
  logic [7:0]  crc_low_seen;
  logic        frame_finished;

  logic [6:0]  byte_count_next;
  logic [15:0] crc_acc_next;
  logic        header_good_next;
  logic        length_good_next;
  logic [7:0]  type_seen_next;
  logic [7:0]  crc_low_seen_next;
  logic        frame_finished_next;

  logic [6:0]  len;
  logic [6:0]  len_m2;
  logic [15:0] crc_fin;
  logic        active;
  logic        last;

  // clamp the frame length into the supported range
  always_comb begin
    if (cfg.frame_length < LenMin) begin
      len = LenMin;
    end else if (cfg.frame_length > LenMax) begin
      len = LenMax;
    end else begin
      len = cfg.frame_length;
    end
    len_m2 = len - 7'd2;
  end

  always_comb begin
    // a first byte restarts the frame before the byte is handled
    if (first) begin
      byte_count_next     = '0;
      crc_acc_next        = CrcInit;
      header_good_next    = 1'b0;
      length_good_next    = 1'b0;
      type_seen_next      = '0;
      crc_low_seen_next   = '0;
      frame_finished_next = 1'b0;
    end else begin
      byte_count_next     = byte_count;
      crc_acc_next        = crc_acc;
      header_good_next    = header_good;
      length_good_next    = length_good;
      type_seen_next      = type_seen;
      crc_low_seen_next   = crc_low_seen;
      frame_finished_next = frame_finished;
    end
    active        = !frame_finished_next;
    last          = 1'b0;
    result_status = ST_OK;
    crc_fin       = ~crc_acc_next;
    if (active) begin
      if (byte_count_next == 7'd0) header_good_next = (rx_byte == cfg.header_value);
      if (byte_count_next == 7'd1) length_good_next = (rx_byte == {1'b0, len});
      if (byte_count_next == 7'd2) type_seen_next = rx_byte;
      if (byte_count_next == len_m2) crc_low_seen_next = rx_byte;
      if (byte_count_next < len_m2) crc_acc_next = crc_byte(crc_acc_next, rx_byte);
      last = (byte_count_next == len - 7'd1);
      if (!header_good_next) begin
        result_status = ST_BAD_HEADER;
      end else if (!length_good_next) begin
        result_status = ST_BAD_LENGTH;
      end else if (type_seen_next == cfg.raw_type_value) begin
        result_status = (crc_low_seen_next == crc_fin[7:0] && rx_byte == crc_fin[15:8])
                        ? ST_OK : ST_BAD_CRC;
      end else if (type_seen_next == cfg.error_type_value) begin
        result_status = ST_ERROR_MSG;
      end else begin
        result_status = ST_UNIDENTIFIED;
      end
      byte_count_next = byte_count_next + 7'd1;
      if (last) frame_finished_next = 1'b1;
    end
    result_valid = active && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      crc_acc        <= CrcInit;
      header_good    <= 1'b0;
      length_good    <= 1'b0;
      type_seen      <= '0;
      crc_low_seen   <= '0;
      frame_finished <= 1'b1;
    end else if (step) begin
      byte_count     <= byte_count_next;
      crc_acc        <= crc_acc_next;
      header_good    <= header_good_next;
      length_good    <= length_good_next;
      type_seen      <= type_seen_next;
      crc_low_seen   <= crc_low_seen_next;
      frame_finished <= frame_finished_next;
    end
  end

endmodule

### hdl/ack_frame_checker_unit.sv
// ack_frame_checker_unit: checks acknowledge frames with a crc-16/x.25 trailer
// depends on afc_pkg and afc_core
//
// usage: received bytes enter on the in channel (rx_byte, first), one transaction
// per byte; set first on the byte that opens a frame. on the frame's last byte
// (frame_length bytes in) one status leaves on the out channel. bytes after the
// status give nothing until the next first byte.
// configuration: cfg channel, cfg_index 0..3 selects header, raw type, error type
// and frame length; other indexes are dropped. cfg_ready is always high.
// path: a byte is held in the input register and its status is then loaded into the
// output register, which drives out_valid and status until the status is taken.
// throughput: one byte per cycle while the output is not stalled, set by the byte-wide
// crc update between the input and output registers.
// stall: while the output holds an untaken status the held byte cannot move on;
// an empty input register still takes one byte, then in_ready stays low until the
// status is taken. nothing is dropped.
// reset: clears both registers and leaves the checker waiting for a first byte;
// configuration goes back to zero with a frame length of 5.
module ack_frame_checker_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       first,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] status
);
  import afc_pkg::*;

  cfg_t       cfg;
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_first;
  logic       advance;
  logic       result_valid;
  status_t    result_status;
  status_t    status_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_value     <= '0;
      cfg.raw_type_value   <= '0;
      cfg.error_type_value <= '0;
      cfg.frame_length     <= LenMin;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEADER:     cfg.header_value <= cfg_data;
        REG_RAW_TYPE:   cfg.raw_type_value <= cfg_data;
        REG_ERROR_TYPE: cfg.error_type_value <= cfg_data;
        REG_FRAME_LEN:  cfg.frame_length <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // the held byte moves on when the output register is free or being emptied
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte  <= rx_byte;
      in_first <= first;
    end
  end

  afc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (advance),
    .rx_byte       (in_byte),
    .first         (in_first),
    .result_valid  (result_valid),
    .result_status (result_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result_valid) begin
      status_reg <= result_status;
    end
  end

  assign status = status_reg;

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_BAD_HEADER))
    else $error("status code out of range");

  a_free_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_full))
    else $error("pipeline not empty after reset");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    (!in_full && (!out_valid || out_ready)) |=> !out_valid)
    else $error("result appeared without a byte in flight");

endmodule
